>>> rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and helpers for the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int REGION_UNITS = 1024;
    localparam int WORD_SHIFT   = 5;
    localparam int WORD_BITS    = 1 << WORD_SHIFT;
    localparam int NUM_WORDS    = (REGION_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int UIDX_W       = WIDX_W + WORD_SHIFT;

    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 11;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = ((UIDX_W > LEN_W) ? UIDX_W : LEN_W) + 1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    // outcome of looking at one map word during the first-fit search
    typedef struct packed {
        logic                   hit;
        logic [WORD_SHIFT-1:0]  hit_pos;
        logic [LEN_W-1:0]       rem_next;
    } scan_res_t;

    // bits of a map word that stand for units inside the region
    function automatic word_t unit_mask(input logic [WIDX_W-1:0] idx);
        word_t       m;
        int unsigned u;
        for (int b = 0; b < WORD_BITS; b++) begin
            u    = (int'(idx) << WORD_SHIFT) + b;
            m[b] = (u < REGION_UNITS);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ffba_req_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: allocate or free, with length and start address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [ffba_pkg::LEN_W-1:0]   length;
    logic [ffba_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output func, output length, output address, input ready);
    modport sink   (input valid, input func, input length, input address, output ready);
endinterface

`default_nettype wire

>>> rtl/ffba_rsp_if.sv
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: allocated block address and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::ADDR_W-1:0]    block_address;
    logic [ffba_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output block_address, output status, input ready);
    modport sink   (input valid, input block_address, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/ffba_cfg_if.sv
// ----------------------------------------------------------------------------
// ffba_cfg_if
// Configuration write channel carrying the region base address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffba_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ffba_pkg::ADDR_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ffba_word_eval.sv
// ----------------------------------------------------------------------------
// ffba_word_eval
// Looks at one map word and finds the first unit where a free run of the
// requested length ends, carrying the run count across word boundaries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_word_eval (
    input  wire logic [ffba_pkg::WORD_BITS-1:0] map_word,
    input  wire logic [ffba_pkg::WIDX_W-1:0]    widx,
    input  wire logic [ffba_pkg::LEN_W-1:0]     length,
    input  wire logic [ffba_pkg::LEN_W-1:0]     rem,
    output      ffba_pkg::scan_res_t            res
);

    localparam int W  = ffba_pkg::WORD_BITS;
    localparam int WS = ffba_pkg::WORD_SHIFT;
    localparam int LW = ffba_pkg::LEN_W;

    ffba_pkg::word_t  free_bits;
    ffba_pkg::word_t  prefix_free;
    ffba_pkg::word_t  reach_mask;
    ffba_pkg::word_t  inner_hits;
    ffba_pkg::word_t  ok;
    logic [LW-1:0]    rem_m1;
    logic [WS:0]      top_run;
    logic             short_req;

    // runs of free units of the given length lying wholly inside the word,
    // built by doubling; runs starting at bit zero are left to prefix_free
    function automatic ffba_pkg::word_t run_hits(input ffba_pkg::word_t f,
                                                 input logic [WS:0] len);
        ffba_pkg::word_t p;
        ffba_pkg::word_t acc;
        p   = f;
        acc = '1;
        for (int m = 0; m <= WS; m++)
        begin
            if (len[m])
            begin
                acc = p & (acc << (1 << m));
            end
            p = p & (p << (1 << m));
        end
        return acc;
    endfunction

    always_comb
    begin
        free_bits = ~map_word & ffba_pkg::unit_mask(widx);

        for (int j = 0; j < W; j++)
        begin
            prefix_free[j] = &(free_bits | ~({W{1'b1}} >> (W - 1 - j)));
        end

        // a run reaching back into earlier words ends here once j+1 >= rem
        rem_m1 = rem - LW'(1);
        if ((rem_m1 >> WS) != '0)
        begin
            reach_mask = '0;
        end
        else
        begin
            reach_mask = {W{1'b1}} << rem_m1[WS-1:0];
        end

        short_req  = (length <= LW'(W));
        inner_hits = short_req ? run_hits(free_bits, length[WS:0]) : '0;
        ok         = (prefix_free & reach_mask) | inner_hits;

        res.hit     = |ok;
        res.hit_pos = '0;
        for (int j = W - 1; j >= 0; j--)
        begin
            if (ok[j])
            begin
                res.hit_pos = WS'(j);
            end
        end

        // free units at the top of the word start the next word's run
        top_run = (WS + 1)'(W);
        for (int j = 0; j < W; j++)
        begin
            if (!free_bits[j])
            begin
                top_run = (WS + 1)'(W - 1 - j);
            end
        end

        if (prefix_free[W-1])
        begin
            res.rem_next = rem - LW'(W);
        end
        else
        begin
            res.rem_next = length - LW'(top_run);
        end
    end

endmodule

`default_nettype wire

>>> rtl/first_fit_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator_core
// First-fit allocator over a bitmap of fixed-size units held in a word RAM.
// ----------------------------------------------------------------------------
// usage:
//   req  : one request per handshake; func 0 allocates length units, func 1
//          frees length units starting at address
//   rsp  : one response per request, in order; block_address is the base of
//          the allocated run (zero otherwise), status 0 done, 1 no room,
//          2 bad request (zero length, or free outside the region)
//   cfg  : writes the region base address, always ready; write only while
//          no request is outstanding
// timing:
//   map words sit in a 32-bit wide RAM, one per cycle through a read-modify-
//   write port. up to 32 words are searched and up to 32 marked per request.
//   the next request is taken in the cycle after the response is loaded;
//   one request at a time.
// reset:
//   every map word reads as free through a per-word valid bit until first
//   written; no clearing pass. base address resets to zero.
// stall:
//   the response sits in an output register; a new request is taken while it
//   waits, and the next response holds until it has gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_bitmap_allocator_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ffba_req_if.sink     req,
    ffba_rsp_if.source   rsp,
    ffba_cfg_if.sink     cfg
);

    localparam int W   = ffba_pkg::WORD_BITS;
    localparam int WS  = ffba_pkg::WORD_SHIFT;
    localparam int WIW = ffba_pkg::WIDX_W;
    localparam int UW  = ffba_pkg::UIDX_W;
    localparam int LW  = ffba_pkg::LEN_W;
    localparam int AW  = ffba_pkg::ADDR_W;
    localparam int SW  = ffba_pkg::SUM_W;
    localparam int NW  = ffba_pkg::NUM_WORDS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_FCHECK = 8'b0000_0100,
        S_FRANGE = 8'b0000_1000,
        S_ASTART = 8'b0001_0000,
        S_MREAD  = 8'b0010_0000,
        S_MARK   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [NW-1:0]                   wvalid_reg, wvalid_next;
    logic [AW-1:0]                   base_reg, base_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            func_reg, func_next;
    logic [LW-1:0]                   len_reg, len_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic [LW-1:0]                   rem_reg, rem_next;
    logic [WIW-1:0]                  eval_idx_reg, eval_idx_next;
    logic [WIW-1:0]                  mk_idx_reg, mk_idx_next;
    logic [UW-1:0]                   first_reg, first_next;
    logic [UW-1:0]                   last_reg, last_next;
    logic [AW-1:0]                   off_reg, off_next;
    logic                            borrow_reg, borrow_next;
    logic [AW-1:0]                   res_addr_reg, res_addr_next;
    logic [ffba_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [AW-1:0]                   out_addr_reg, out_addr_next;
    logic [ffba_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                            ram_we;
    logic [WIW-1:0]                  ram_waddr;
    ffba_pkg::word_t                 ram_wdata;
    logic                            ram_re;
    logic [WIW-1:0]                  ram_raddr;
    ffba_pkg::word_t                 ram_rdata;

    ffba_pkg::word_t                 scan_word;
    ffba_pkg::scan_res_t             scan_res;

    ffba_pkg::word_t                 mark_word;
    ffba_pkg::word_t                 mark_mask;
    logic [WS-1:0]                   mark_lo;
    logic [WS-1:0]                   mark_hi;
    logic [WIW-1:0]                  first_word;
    logic [WIW-1:0]                  last_word;
    logic [AW:0]                     diff;
    logic                            in_region;
    logic                            fits;

    assign req.ready         = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.status        = out_status_reg;

    assign first_word = first_reg[UW-1:WS];
    assign last_word  = last_reg[UW-1:WS];

    // words never written read as all free
    assign scan_word = wvalid_reg[eval_idx_reg] ? ram_rdata : '0;
    assign mark_word = wvalid_reg[mk_idx_reg] ? ram_rdata : '0;

    ffba_ram #(
        .WIDTH (W),
        .DEPTH (NW),
        .AW    (WIW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffba_word_eval u_word_eval (
        .map_word (scan_word),
        .widx     (eval_idx_reg),
        .length   (len_reg),
        .rem      (rem_reg),
        .res      (scan_res)
    );

    always_comb
    begin
        mark_lo   = (mk_idx_reg == first_word) ? first_reg[WS-1:0] : '0;
        mark_hi   = (mk_idx_reg == last_word) ? last_reg[WS-1:0] : WS'(W - 1);
        mark_mask = ({W{1'b1}} << mark_lo) & ({W{1'b1}} >> (WS'(W - 1) - mark_hi));

        diff      = {1'b0, addr_reg} - {1'b0, base_reg};
        in_region = !borrow_reg && (off_reg < AW'(ffba_pkg::REGION_UNITS));
        fits      = (SW'(off_reg[UW-1:0]) + SW'(len_reg)) <= SW'(ffba_pkg::REGION_UNITS);
    end

    always_comb
    begin
        state_next      = state_reg;
        wvalid_next     = wvalid_reg;
        base_next       = base_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        len_next        = len_reg;
        addr_next       = addr_reg;
        rem_next        = rem_reg;
        eval_idx_next   = eval_idx_reg;
        mk_idx_next     = mk_idx_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        off_next        = off_reg;
        borrow_next     = borrow_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = mk_idx_reg;
        ram_wdata = mark_word;
        ram_re    = 1'b0;
        ram_raddr = '0;

        if (cfg.valid)
        begin
            base_next = cfg.data;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next       = req.func;
                    len_next        = req.length;
                    addr_next       = req.address;
                    rem_next        = req.length;
                    eval_idx_next   = '0;
                    res_addr_next   = '0;
                    res_status_next = ffba_pkg::ST_DONE;
                    if (req.length == '0)
                    begin
                        res_status_next = ffba_pkg::ST_BAD;
                        state_next      = S_RESP;
                    end
                    else if (req.func == ffba_pkg::FUNC_ALLOC)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FCHECK;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_res.hit)
                begin
                    last_next  = {eval_idx_reg, scan_res.hit_pos};
                    state_next = S_ASTART;
                end
                else if (eval_idx_reg == WIW'(NW - 1))
                begin
                    res_status_next = ffba_pkg::ST_NOROOM;
                    state_next      = S_RESP;
                end
                else
                begin
                    rem_next      = scan_res.rem_next;
                    eval_idx_next = eval_idx_reg + WIW'(1);
                    ram_re        = 1'b1;
                    ram_raddr     = eval_idx_reg + WIW'(1);
                end
            end

            S_FCHECK:
            begin
                borrow_next = diff[AW];
                off_next    = diff[AW-1:0];
                state_next  = S_FRANGE;
            end

            S_FRANGE:
            begin
                if (in_region && fits)
                begin
                    first_next = off_reg[UW-1:0];
                    last_next  = off_reg[UW-1:0] + UW'(len_reg) - UW'(1);
                    state_next = S_MREAD;
                end
                else
                begin
                    res_status_next = ffba_pkg::ST_BAD;
                    state_next      = S_RESP;
                end
            end

            S_ASTART:
            begin
                first_next = last_reg - UW'(len_reg) + UW'(1);
                state_next = S_MREAD;
            end

            S_MREAD:
            begin
                if (func_reg == ffba_pkg::FUNC_ALLOC)
                begin
                    res_addr_next = base_reg + AW'(first_reg);
                end
                mk_idx_next = first_word;
                ram_re      = 1'b1;
                ram_raddr   = first_word;
                state_next  = S_MARK;
            end

            S_MARK:
            begin
                // write back this word while the next one is read
                ram_we = 1'b1;
                if (func_reg == ffba_pkg::FUNC_ALLOC)
                begin
                    ram_wdata = mark_word | mark_mask;
                end
                else
                begin
                    ram_wdata = mark_word & ~mark_mask;
                end
                wvalid_next[mk_idx_reg] = 1'b1;
                if (mk_idx_reg == last_word)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mk_idx_next = mk_idx_reg + WIW'(1);
                    ram_re      = 1'b1;
                    ram_raddr   = mk_idx_reg + WIW'(1);
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wvalid_reg    <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wvalid_reg    <= wvalid_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        len_reg        <= len_next;
        addr_reg       <= addr_next;
        rem_reg        <= rem_next;
        eval_idx_reg   <= eval_idx_next;
        mk_idx_reg     <= mk_idx_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        off_reg        <= off_next;
        borrow_reg     <= borrow_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire
